FILE: design/grid_dda_column_raycaster_defines.svh
// Assertion macros for the checker file.
`ifndef GRID_DDA_COLUMN_RAYCASTER_DEFINES_SVH
`define GRID_DDA_COLUMN_RAYCASTER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define GDDA_ASSERT_IMP(name, pre, post) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("grid raycaster check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define GDDA_ASSERT_NEXT(name, pre, post) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("grid raycaster check failed");

`endif

FILE: design/gdda_pkg.sv
`default_nettype none
package gdda_pkg;
	localparam int CFG_W = 22;
	localparam int IDX_W = 3;

	localparam logic [IDX_W-1:0] REG_POS_X   = 3'd0;
	localparam logic [IDX_W-1:0] REG_POS_Y   = 3'd1;
	localparam logic [IDX_W-1:0] REG_DIR_X   = 3'd2;
	localparam logic [IDX_W-1:0] REG_DIR_Y   = 3'd3;
	localparam logic [IDX_W-1:0] REG_PLANE_X = 3'd4;
	localparam logic [IDX_W-1:0] REG_PLANE_Y = 3'd5;
	localparam logic [IDX_W-1:0] REG_TEX_W   = 3'd6;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_CAST  = 1'b1;

	localparam logic [1:0] FACE_EAST  = 2'd0;
	localparam logic [1:0] FACE_WEST  = 2'd1;
	localparam logic [1:0] FACE_SOUTH = 2'd2;
	localparam logic [1:0] FACE_NORTH = 2'd3;

	localparam logic [23:0] DIST_MAX = 24'hFFFFFF;

	typedef struct packed {
		logic       operation;
		logic [9:0] column;
		logic [5:0] cell_x;
		logic [5:0] cell_y;
		logic       wall;
	} cmd_t;

	typedef struct packed {
		logic [9:0]  column_out;
		logic [5:0]  hit_x;
		logic [5:0]  hit_y;
		logic        hit_side;
		logic [1:0]  face;
		logic [23:0] wall_dist;
		logic [8:0]  slice_top;
		logic [8:0]  slice_bot;
		logic [7:0]  tex_col;
	} res_t;
endpackage
`default_nettype wire

FILE: design/gdda_div.sv
`default_nettype none
module gdda_div import gdda_pkg::*; #(
	parameter int NW = 31,
	parameter int DW = 40
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [NW-1:0] num,
	input  wire logic [DW-1:0] den,
	output logic               done,
	output logic [NW-1:0]      quo
);
	localparam int CW = $clog2(NW + 1);

	logic [CW-1:0] cnt_q;
	logic          run_q;
	logic          done_q;
	logic [DW:0]   rem_q;
	logic [NW-1:0] quo_q;
	logic [DW-1:0] den_q;
	logic [DW:0]   rem_sh;
	logic          ge;
	logic [DW:0]   rem_nx;

	always_comb begin
		rem_sh = {rem_q[DW-1:0], quo_q[NW-1]};
		ge     = rem_sh >= {1'b0, den_q};
		rem_nx = ge ? rem_sh - {1'b0, den_q} : rem_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CW'(NW);
				run_q <= 1'b1;
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (run_q) begin
			rem_q <= rem_nx;
			quo_q <= {quo_q[NW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
endmodule
`default_nettype wire

FILE: design/grid_dda_column_raycaster.sv
// channel  | signals                    | item
// cmd      | cmd_valid cmd_ready cmd    | map write or ray cast request
// res      | res_valid res_ready res    | one hit result per cast
// cfg      | cfg_we cfg_idx cfg_data    | camera and texture registers
// A map write is stored in the grid memory when it is accepted. A cast runs
// from accept to result load: the camera offset is a reciprocal multiply,
// three divisions share the one serial divider, and each DDA step is a map
// read from the grid memory.
// After reset all MAP_DIM*MAP_DIM grid cells are cleared, one cell a cycle,
// with cmd_ready low. A held result in the res register does not stall a new
// cast; only the final load waits for the register to free up.
`default_nettype none
module grid_dda_column_raycaster import gdda_pkg::*; #(
	parameter int MAP_DIM  = 64,
	parameter int SCREEN_W = 640,
	parameter int SCREEN_H = 480
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cmd_valid,
	output logic                  cmd_ready,
	input  wire cmd_t             cmd,
	output logic                  res_valid,
	input  wire logic             res_ready,
	output res_t                  res,
	input  wire logic             cfg_we,
	input  wire logic [IDX_W-1:0] cfg_idx,
	input  wire logic [CFG_W-1:0] cfg_data
);
	localparam int MB    = $clog2(MAP_DIM);
	localparam int DEPTH = MAP_DIM * MAP_DIM;
	localparam int AW    = $clog2(DEPTH);
	localparam int MW    = (MB > 6 ? MB : 6) + 2;
	localparam int GUARD = 2 * MAP_DIM + 4;
	localparam int GW    = $clog2(GUARD + 1);
	localparam int SW    = 32 + GW;
	localparam int NW    = 31;
	localparam int RW    = 18;
	localparam int CAMW  = ($clog2(SCREEN_W) > 11 ? $clog2(SCREEN_W) : 11) + 2;
	localparam int PW    = 16 + CAMW;
	localparam int HW    = $clog2(2 * SCREEN_H + 1);
	localparam logic [31:0] RECIP = 32'((64'd1 << 32) / SCREEN_W);

	localparam logic [3:0] ST_CLEAR = 4'd0;
	localparam logic [3:0] ST_IDLE  = 4'd1;
	localparam logic [3:0] ST_MUL   = 4'd2;
	localparam logic [3:0] ST_DIV   = 4'd3;
	localparam logic [3:0] ST_DIVW  = 4'd4;
	localparam logic [3:0] ST_RAY   = 4'd5;
	localparam logic [3:0] ST_SIDE  = 4'd6;
	localparam logic [3:0] ST_STEP  = 4'd7;
	localparam logic [3:0] ST_CHECK = 4'd8;
	localparam logic [3:0] ST_PERP  = 4'd9;
	localparam logic [3:0] ST_TEX1  = 4'd10;
	localparam logic [3:0] ST_TEX2  = 4'd11;
	localparam logic [3:0] ST_OUT   = 4'd12;
	localparam logic [3:0] ST_QMUL  = 4'd13;
	localparam logic [3:0] ST_QREM  = 4'd14;
	localparam logic [3:0] ST_QFIX  = 4'd15;

	localparam logic [2:0] DIV_DX = 3'd2;
	localparam logic [2:0] DIV_DY = 3'd3;
	localparam logic [2:0] DIV_LH = 3'd4;

	logic [3:0]  state_q;
	logic [2:0]  div_id_q;
	logic [AW-1:0] clr_q;

	logic [21:0]       pos_x_q, pos_y_q;
	logic signed [15:0] dir_x_q, dir_y_q, plane_x_q, plane_y_q;
	logic [8:0]        tex_w_q;

	logic [9:0]          col_q;
	logic signed [PW-1:0] pmx_q, pmy_q;
	logic [PW-1:0]       q0x_q, q0y_q, remx_q, remy_q;
	logic signed [RW-1:0] qx_q, qy_q, rx_q, ry_q;
	logic [NW-1:0]       dx_q, dy_q;
	logic [SW-1:0]       sx_q, sy_q, perp_q;
	logic signed [MW-1:0] mx_q, my_q;
	logic                side_q;
	logic [GW-1:0]       guard_q;
	logic                rd_q, oob_q;
	logic [HW-1:0]       lh_q, ds_q, de_q;
	logic [29:0]         prod_q;
	logic [7:0]          tex_q;
	res_t                res_q;
	logic                res_valid_q;

	logic mem [DEPTH];

	// serial divider
	logic          div_start, div_done;
	logic [NW-1:0] div_num, div_quo;
	logic [SW-1:0] div_den;

	gdda_div #(.NW(NW), .DW(SW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	logic signed [CAMW-1:0] cam;
	logic inf_x, inf_y, both;
	logic [RW-1:0] ax, ay;

	assign cam   = $signed(CAMW'({col_q, 1'b0})) - $signed(CAMW'(SCREEN_W));
	assign inf_x = rx_q == '0;
	assign inf_y = ry_q == '0;
	assign both  = inf_x && inf_y;
	assign ax    = $unsigned(rx_q[RW-1] ? -rx_q : rx_q);
	assign ay    = $unsigned(ry_q[RW-1] ? -ry_q : ry_q);

	always_comb begin
		div_num = '0;
		div_den = '0;
		case (div_id_q)
			DIV_DX: begin
				div_num = NW'(31'h4000_0000);
				div_den = SW'(ax);
			end
			DIV_DY: begin
				div_num = NW'(31'h4000_0000);
				div_den = SW'(ay);
			end
			DIV_LH: begin
				div_num = NW'(SCREEN_H) << 16;
				div_den = perp_q;
			end
			default: ;
		endcase
	end
	assign div_start = state_q == ST_DIV;

	// camera offset: floored quotient by SCREEN_W via reciprocal and one correction
	logic [PW-1:0]        mag_x, mag_y, fix_x, fix_y;
	logic [PW+31:0]       rcp_x, rcp_y;
	logic                 hi_x, hi_y, nz_x, nz_y;
	logic signed [RW-1:0] q_x_n, q_y_n;
	always_comb begin
		mag_x = $unsigned(pmx_q[PW-1] ? -pmx_q : pmx_q);
		mag_y = $unsigned(pmy_q[PW-1] ? -pmy_q : pmy_q);
		rcp_x = (PW + 32)'(mag_x) * (PW + 32)'(RECIP);
		rcp_y = (PW + 32)'(mag_y) * (PW + 32)'(RECIP);
		hi_x  = remx_q >= PW'(SCREEN_W);
		hi_y  = remy_q >= PW'(SCREEN_W);
		fix_x = hi_x ? q0x_q + PW'(1) : q0x_q;
		fix_y = hi_y ? q0y_q + PW'(1) : q0y_q;
		nz_x  = hi_x ? remx_q != PW'(SCREEN_W) : remx_q != '0;
		nz_y  = hi_y ? remy_q != PW'(SCREEN_W) : remy_q != '0;
		q_x_n = pmx_q[PW-1] ? -$signed(RW'(fix_x)) - $signed(RW'(nz_x))
			: $signed(RW'(fix_x));
		q_y_n = pmy_q[PW-1] ? -$signed(RW'(fix_y)) - $signed(RW'(nz_y))
			: $signed(RW'(fix_y));
	end

	// start side distances
	logic [16:0] fdx, fdy;
	logic [47:0] sxp, syp;
	assign fdx = rx_q[RW-1] ? {1'b0, pos_x_q[15:0]} : 17'd65536 - {1'b0, pos_x_q[15:0]};
	assign fdy = ry_q[RW-1] ? {1'b0, pos_y_q[15:0]} : 17'd65536 - {1'b0, pos_y_q[15:0]};
	assign sxp = 48'(fdx) * 48'(dx_q);
	assign syp = 48'(fdy) * 48'(dy_q);

	// DDA step
	logic                 take_x, oob_n;
	logic signed [MW-1:0] mx_n, my_n;
	logic [AW-1:0]        addr_n;
	always_comb begin
		take_x = both ? (sx_q < sy_q) : (!inf_x && (inf_y || sx_q < sy_q));
		mx_n   = mx_q;
		my_n   = my_q;
		if (take_x)
			mx_n = rx_q[RW-1] ? mx_q - MW'(1) : mx_q + MW'(1);
		else
			my_n = ry_q[RW-1] ? my_q - MW'(1) : my_q + MW'(1);
		oob_n  = mx_n[MW-1] || my_n[MW-1] || mx_n >= $signed(MW'(MAP_DIM))
			|| my_n >= $signed(MW'(MAP_DIM));
		addr_n = AW'(AW'(my_n[MB-1:0]) * AW'(MAP_DIM) + AW'(mx_n[MB-1:0]));
	end

	// line height and slice rows
	logic [HW-1:0] lh_n, half;
	logic [HW:0]   de_sum;
	always_comb begin
		if (both)
			lh_n = '0;
		else if (perp_q == '0 || div_quo > NW'(2 * SCREEN_H))
			lh_n = HW'(2 * SCREEN_H);
		else
			lh_n = HW'(div_quo);
		half   = lh_q >> 1;
		de_sum = (HW + 1)'(half) + (HW + 1)'(SCREEN_H / 2);
	end

	// texture column
	logic [29:0] pa, pb, prod_n, frac30;
	logic [21:0] base;
	logic [8:0]  tw, tex_t, tex_o;
	logic [38:0] tex_p;
	logic        keep;
	always_comb begin
		pa     = perp_q[29:0];
		pb     = $unsigned(30'(side_q ? rx_q : ry_q));
		prod_n = both ? 30'd0 : pa * pb;
		base   = side_q ? pos_x_q : pos_y_q;
		frac30 = {base[15:0], 14'd0} + prod_q;
		if (tex_w_q == 9'd0)
			tw = 9'd1;
		else if (tex_w_q > 9'd256)
			tw = 9'd256;
		else
			tw = tex_w_q;
		tex_p  = 39'(frac30) * 39'(tw);
		tex_t  = tex_p[38:30];
		keep   = side_q ? ry_q[RW-1] : (!rx_q[RW-1] && !inf_x);
		tex_o  = keep ? tex_t : tw - 9'd1 - tex_t;
	end

	// grid memory
	logic          cmd_acc, wr_acc, mem_we, mem_wd;
	logic [AW-1:0] addr_w, mem_wa;
	assign cmd_ready = state_q == ST_IDLE;
	assign cmd_acc   = cmd_valid && cmd_ready;
	assign wr_acc    = cmd_acc && cmd.operation == OP_WRITE
		&& 32'(cmd.cell_x) < MAP_DIM && 32'(cmd.cell_y) < MAP_DIM;
	assign addr_w    = AW'(AW'(cmd.cell_y) * AW'(MAP_DIM) + AW'(cmd.cell_x));
	assign mem_we    = state_q == ST_CLEAR || wr_acc;
	assign mem_wa    = state_q == ST_CLEAR ? clr_q : addr_w;
	assign mem_wd    = state_q == ST_CLEAR ? 1'b0 : cmd.wall;

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= mem_wd;
		if (state_q == ST_STEP)
			rd_q <= mem[addr_n];
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q   <= 22'd2097152;
			pos_y_q   <= 22'd2097152;
			dir_x_q   <= -16'sd16384;
			dir_y_q   <= '0;
			plane_x_q <= '0;
			plane_y_q <= 16'sd10813;
			tex_w_q   <= 9'd64;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_POS_X:   pos_x_q   <= cfg_data[21:0];
				REG_POS_Y:   pos_y_q   <= cfg_data[21:0];
				REG_DIR_X:   dir_x_q   <= cfg_data[15:0];
				REG_DIR_Y:   dir_y_q   <= cfg_data[15:0];
				REG_PLANE_X: plane_x_q <= cfg_data[15:0];
				REG_PLANE_Y: plane_y_q <= cfg_data[15:0];
				REG_TEX_W:   tex_w_q   <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	logic res_load;
	assign res_load = state_q == ST_OUT && (!res_valid_q || res_ready);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			div_id_q    <= DIV_DX;
			clr_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (res_load)
				res_valid_q <= 1'b1;
			else if (res_ready)
				res_valid_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(DEPTH - 1))
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (cmd_acc && cmd.operation == OP_CAST)
						state_q <= ST_MUL;
				end
				ST_MUL:  state_q <= ST_QMUL;
				ST_QMUL: state_q <= ST_QREM;
				ST_QREM: state_q <= ST_QFIX;
				ST_QFIX: state_q <= ST_RAY;
				ST_DIV:  state_q <= ST_DIVW;
				ST_DIVW: begin
					if (div_done) begin
						unique case (div_id_q)
							DIV_DX: begin
								div_id_q <= DIV_DY;
								state_q  <= ST_DIV;
							end
							DIV_DY: state_q <= ST_SIDE;
							default: state_q <= ST_TEX1;
						endcase
					end
				end
				ST_RAY: begin
					div_id_q <= DIV_DX;
					state_q  <= ST_DIV;
				end
				ST_SIDE: state_q <= ST_STEP;
				ST_STEP: state_q <= ST_CHECK;
				ST_CHECK: begin
					if (oob_q || rd_q || guard_q == GW'(GUARD))
						state_q <= ST_PERP;
					else
						state_q <= ST_STEP;
				end
				ST_PERP: begin
					div_id_q <= DIV_LH;
					state_q  <= ST_DIV;
				end
				ST_TEX1: state_q <= ST_TEX2;
				ST_TEX2: state_q <= ST_OUT;
				ST_OUT: begin
					if (res_load)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: col_q <= cmd.column;
			ST_MUL: begin
				pmx_q <= plane_x_q * cam;
				pmy_q <= plane_y_q * cam;
			end
			ST_QMUL: begin
				q0x_q <= rcp_x[PW+31:32];
				q0y_q <= rcp_y[PW+31:32];
			end
			ST_QREM: begin
				remx_q <= mag_x - q0x_q * PW'(SCREEN_W);
				remy_q <= mag_y - q0y_q * PW'(SCREEN_W);
			end
			ST_QFIX: begin
				qx_q <= q_x_n;
				qy_q <= q_y_n;
			end
			ST_DIVW: begin
				if (div_done) begin
					case (div_id_q)
						DIV_DX: dx_q <= inf_x ? NW'(65536) : div_quo;
						DIV_DY: dy_q <= inf_y ? NW'(65536) : div_quo;
						default: lh_q <= lh_n;
					endcase
				end
			end
			ST_RAY: begin
				rx_q <= RW'(dir_x_q) + qx_q;
				ry_q <= RW'(dir_y_q) + qy_q;
			end
			ST_SIDE: begin
				sx_q    <= SW'(sxp >> 16);
				sy_q    <= SW'(syp >> 16);
				mx_q    <= MW'(pos_x_q[21:16]);
				my_q    <= MW'(pos_y_q[21:16]);
				side_q  <= 1'b0;
				guard_q <= '0;
			end
			ST_STEP: begin
				if (take_x)
					sx_q <= sx_q + SW'(dx_q);
				else
					sy_q <= sy_q + SW'(dy_q);
				mx_q    <= mx_n;
				my_q    <= my_n;
				side_q  <= !take_x;
				guard_q <= guard_q + 1'b1;
				oob_q   <= oob_n;
			end
			ST_PERP: perp_q <= side_q ? sy_q - SW'(dy_q) : sx_q - SW'(dx_q);
			ST_TEX1: begin
				prod_q <= prod_n;
				ds_q   <= half >= HW'(SCREEN_H / 2) ? '0 : HW'(SCREEN_H / 2) - half;
				de_q   <= de_sum >= (HW + 1)'(SCREEN_H) ? HW'(SCREEN_H - 1) : HW'(de_sum);
			end
			ST_TEX2: tex_q <= tex_o[7:0];
			default: ;
		endcase
		if (res_load) begin
			res_q.column_out <= col_q;
			res_q.hit_x      <= mx_q[5:0];
			res_q.hit_y      <= my_q[5:0];
			res_q.hit_side   <= side_q;
			if (side_q)
				res_q.face <= ry_q[RW-1] ? FACE_NORTH : FACE_SOUTH;
			else
				res_q.face <= rx_q[RW-1] ? FACE_WEST : FACE_EAST;
			if (both || perp_q > SW'(DIST_MAX))
				res_q.wall_dist <= DIST_MAX;
			else
				res_q.wall_dist <= perp_q[23:0];
			res_q.slice_top <= 9'(ds_q);
			res_q.slice_bot <= 9'(de_q);
			res_q.tex_col   <= tex_q;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;
endmodule
`default_nettype wire

FILE: design/gdda_checker.sv
`default_nettype none
`include "grid_dda_column_raycaster_defines.svh"
module gdda_checker import gdda_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cmd_valid,
	input wire logic cmd_ready,
	input wire cmd_t cmd,
	input wire logic res_valid,
	input wire logic res_ready,
	input wire res_t res
);
	`GDDA_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res))
	`GDDA_ASSERT_IMP(a_face_side, res_valid, res.face[1] == res.hit_side)
	`GDDA_ASSERT_NEXT(a_cast_busy, cmd_valid && cmd_ready && cmd.operation == OP_CAST, !cmd_ready)
endmodule

bind grid_dda_column_raycaster gdda_checker u_gdda_checker (.*);
`default_nettype wire
